// ===== sv/fw3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fw3d_pkg
// Shared types and constants of the 3D Fenwick tree range-sum core.
// ----------------------------------------------------------------------------
package fw3d_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_TERM,
    ST_Q_READ,
    ST_Q_DRAIN,
    ST_OUT,
    ST_U_READ,
    ST_U_WRITE
  } state_t;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SIDE = 1'b0;

  localparam logic [4:0] SIDE_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== sv/fenwick_tree_3d_range_sum_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_tree_3d_range_sum_core
// 3D Fenwick tree of 32-bit cells: point updates and box sum queries.
// ----------------------------------------------------------------------------
// Usage: an input word (kind, corners, delta) is taken when in_valid and
// in_ready are high; in_ready is high only while the core is idle. An update
// word gives no output word. A query word gives one output word (box_total,
// bad_coordinate) that is held on the output until out_ready takes it; while
// it waits, no new input word is taken.
// Operation, all through the single cell memory port and one shared adder:
//   update: each touched cell is read, then written back; the touched cells
//           number cx * cy * cz with c the upward chain lengths (up to 5 at 16).
//   query:  a setup step per term, a read per cell over the eight downward
//           chain products, a drain step, then the output word.
//   bad coordinate: query answers in the next cycle, update is dropped.
// Reset: the cell memory is swept to zero, one cell per cycle, over all
// 2^(3*clog2(MAX_SIDE)) cells (4096 at MAX_SIDE = 16); in_ready stays low
// meanwhile. APB writes to side_in_use are taken at any time.
// ----------------------------------------------------------------------------
module fenwick_tree_3d_range_sum_core #(
  parameter int MAX_SIDE = 16
) (
  input  wire               clk,
  input  wire               rst,
  // config port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               kind,
  input  wire  [3:0]        x_low,
  input  wire  [3:0]        y_low,
  input  wire  [3:0]        z_low,
  input  wire  [3:0]        x_high,
  input  wire  [3:0]        y_high,
  input  wire  [3:0]        z_high,
  input  wire  signed [31:0] delta,
  // output channel
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] box_total,
  output logic              bad_coordinate
);

  localparam int IW = $clog2(MAX_SIDE);
  localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;
  localparam int AW = 3 * IW;

  fw3d_pkg::state_t state, state_next;

  logic [4:0]    side;
  logic [CW-1:0] eff_side;

  logic [CW-1:0] ci, cj, ck, ci_next, cj_next, ck_next;
  logic [CW-1:0] j0, k0, j0_next, k0_next;
  logic [3:0]    xl, yl, zl, xh, yh, zh;
  logic [2:0]    term, term_next;
  logic [31:0]   acc, acc_next;
  logic [31:0]   delta_q;
  logic          bad, bad_next;
  logic [AW-1:0] clr_addr, clr_addr_next;

  logic          rd_valid, rd_sign;
  logic [31:0]   rdata;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   cells [2**AW];

  logic [31:0]   add_a, add_b, add_sum;
  logic          add_sub;

  logic          in_bad_hi, in_bad_lo;
  logic [CW-1:0] xs, ys, zs;
  logic          term_skip;

  function automatic logic [CW-1:0] down_and(input logic [CW-1:0] v);
    down_and = v & (v + CW'(1));
  endfunction

  function automatic logic [CW-1:0] up_or(input logic [CW-1:0] v);
    up_or = v | (v + CW'(1));
  endfunction

  // side_in_use above MAX_SIDE saturates
  always_comb begin
    if (32'(side) > 32'(MAX_SIDE)) begin
      eff_side = CW'(MAX_SIDE);
    end else begin
      eff_side = CW'(side);
    end
  end

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fw3d_pkg::REG_SIDE) ? {27'd0, side} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= fw3d_pkg::SIDE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == fw3d_pkg::REG_SIDE) begin
      side <= pwdata[4:0];
    end
  end

  assign in_bad_hi = (CW'(x_high) >= eff_side) || (CW'(y_high) >= eff_side) ||
                     (CW'(z_high) >= eff_side);
  assign in_bad_lo = (CW'(x_low) >= eff_side) || (CW'(y_low) >= eff_side) ||
                     (CW'(z_low) >= eff_side);

  // term t: bit 0 picks x_low-1, bit 1 y_low-1, bit 2 z_low-1
  assign xs = term[0] ? CW'(xl) - CW'(1) : CW'(xh);
  assign ys = term[1] ? CW'(yl) - CW'(1) : CW'(yh);
  assign zs = term[2] ? CW'(zl) - CW'(1) : CW'(zh);
  assign term_skip = (term[0] && xl == 4'd0) || (term[1] && yl == 4'd0) ||
                     (term[2] && zl == 4'd0);

  // shared adder: accumulate for queries, add delta for updates
  always_comb begin
    if (state == fw3d_pkg::ST_U_WRITE) begin
      add_a   = delta_q;
      add_sub = 1'b0;
    end else begin
      add_a   = acc;
      add_sub = rd_sign;
    end
    add_b   = add_sub ? ~rdata : rdata;
    add_sum = add_a + add_b + {31'd0, add_sub};
  end

  assign in_ready       = (state == fw3d_pkg::ST_IDLE);
  assign out_valid      = (state == fw3d_pkg::ST_OUT);
  assign box_total      = acc;
  assign bad_coordinate = bad;

  always_comb begin
    state_next    = state;
    ci_next       = ci;
    cj_next       = cj;
    ck_next       = ck;
    j0_next       = j0;
    k0_next       = k0;
    term_next     = term;
    acc_next      = rd_valid ? add_sum : acc;
    bad_next      = bad;
    clr_addr_next = clr_addr;
    mem_we        = 1'b0;
    mem_addr      = {ci[IW-1:0], cj[IW-1:0], ck[IW-1:0]};
    mem_wdata     = add_sum;

    unique case (state)
      fw3d_pkg::ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_addr      = clr_addr;
        mem_wdata     = 32'd0;
        clr_addr_next = clr_addr + AW'(1);
        if (&clr_addr) begin
          state_next = fw3d_pkg::ST_IDLE;
        end
      end

      fw3d_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (kind == fw3d_pkg::KIND_QUERY) begin
            acc_next = 32'd0;
            if (in_bad_hi || in_bad_lo) begin
              bad_next   = 1'b1;
              state_next = fw3d_pkg::ST_OUT;
            end else begin
              bad_next   = 1'b0;
              term_next  = 3'd0;
              state_next = fw3d_pkg::ST_Q_TERM;
            end
          end else if (!in_bad_hi) begin
            ci_next    = CW'(x_high);
            cj_next    = CW'(y_high);
            ck_next    = CW'(z_high);
            j0_next    = CW'(y_high);
            k0_next    = CW'(z_high);
            state_next = fw3d_pkg::ST_U_READ;
          end
        end
      end

      fw3d_pkg::ST_Q_TERM: begin
        if (term_skip) begin
          term_next  = term + 3'd1;
          state_next = (&term) ? fw3d_pkg::ST_Q_DRAIN : fw3d_pkg::ST_Q_TERM;
        end else begin
          ci_next    = xs;
          cj_next    = ys;
          ck_next    = zs;
          j0_next    = ys;
          k0_next    = zs;
          state_next = fw3d_pkg::ST_Q_READ;
        end
      end

      fw3d_pkg::ST_Q_READ: begin
        // walk k innermost along (v & (v+1)) - 1 until it would go negative
        if (down_and(ck) != '0) begin
          ck_next = down_and(ck) - CW'(1);
        end else begin
          ck_next = k0;
          if (down_and(cj) != '0) begin
            cj_next = down_and(cj) - CW'(1);
          end else begin
            cj_next = j0;
            if (down_and(ci) != '0) begin
              ci_next = down_and(ci) - CW'(1);
            end else begin
              term_next  = term + 3'd1;
              state_next = (&term) ? fw3d_pkg::ST_Q_DRAIN : fw3d_pkg::ST_Q_TERM;
            end
          end
        end
      end

      fw3d_pkg::ST_Q_DRAIN: begin
        state_next = fw3d_pkg::ST_OUT;
      end

      fw3d_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = fw3d_pkg::ST_IDLE;
        end
      end

      fw3d_pkg::ST_U_READ: begin
        state_next = fw3d_pkg::ST_U_WRITE;
      end

      fw3d_pkg::ST_U_WRITE: begin
        mem_we     = 1'b1;
        state_next = fw3d_pkg::ST_U_READ;
        if (up_or(ck) < eff_side) begin
          ck_next = up_or(ck);
        end else begin
          ck_next = k0;
          if (up_or(cj) < eff_side) begin
            cj_next = up_or(cj);
          end else begin
            cj_next = j0;
            if (up_or(ci) < eff_side) begin
              ci_next = up_or(ci);
            end else begin
              state_next = fw3d_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = fw3d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fw3d_pkg::ST_CLEAR;
      clr_addr <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      rd_valid <= (state == fw3d_pkg::ST_Q_READ);
    end
  end

  always_ff @(posedge clk) begin
    ci      <= ci_next;
    cj      <= cj_next;
    ck      <= ck_next;
    j0      <= j0_next;
    k0      <= k0_next;
    term    <= term_next;
    acc     <= acc_next;
    bad     <= bad_next;
    rd_sign <= ^term;
    if (state == fw3d_pkg::ST_IDLE && in_valid) begin
      xl      <= x_low;
      yl      <= y_low;
      zl      <= z_low;
      xh      <= x_high;
      yh      <= y_high;
      zh      <= z_high;
      delta_q <= delta;
    end
  end

  // cell memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_addr] <= mem_wdata;
    end
    rdata <= cells[mem_addr];
  end

endmodule

`default_nettype wire
